@@ rtl/core/dual_trigger_adc_scaler_defines.svh @@
// ----------------------------------------------------------------------------
// Dual trigger ADC scaler assertion macros
// Shared concurrent assertion forms used by the checker of the scaler.
// ----------------------------------------------------------------------------
`ifndef DUAL_TRIGGER_ADC_SCALER_DEFINES_SVH
`define DUAL_TRIGGER_ADC_SCALER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked a fixed number of cycles later.
`define DTAS_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dtas_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual trigger ADC scaler package
// Widths, constants, register indexes and item types shared by the scaler.
// ----------------------------------------------------------------------------
package dtas_pkg;

  localparam int unsigned ADC_W  = 12;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned FULL_W = ADC_W + 1;
  localparam int unsigned QUO_W  = LVL_W;
  localparam int unsigned DIV_W  = FULL_W + QUO_W - 1;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned LATENCY = QUO_W + 2;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 8'd255;

  localparam logic [ADC_W-1:0]  RELEASE_RST = 12'd4095;
  localparam logic [FULL_W-1:0] FULL_RST    = 13'd0;

  typedef enum logic [IDX_W-1:0] {
    CFG_LEFT_RELEASE  = 2'd0,
    CFG_LEFT_FULL     = 2'd1,
    CFG_RIGHT_RELEASE = 2'd2,
    CFG_RIGHT_FULL    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_DIV
  } mode_e;

  typedef struct packed {
    logic [ADC_W-1:0] raw_left;
    logic [ADC_W-1:0] raw_right;
    logic [LVL_W-1:0] left_level_in;
    logic [LVL_W-1:0] right_level_in;
    logic             left_bit_in;
    logic             right_bit_in;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] left_level_out;
    logic [LVL_W-1:0] right_level_out;
    logic             left_bit_out;
    logic             right_bit_out;
  } out_item_t;

  typedef struct packed {
    mode_e            mode;
    logic [LVL_W-1:0] level_in;
    logic             bit_in;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } div_cell_t;

endpackage

@@ rtl/core/dtas_prep.sv @@
// ----------------------------------------------------------------------------
// Dual trigger ADC scaler channel front end
// Classifies one sample against its thresholds and sets up the division.
// ----------------------------------------------------------------------------
module dtas_prep (
  input  logic [dtas_pkg::ADC_W-1:0]         raw_i,
  input  logic [dtas_pkg::ADC_W-1:0]         release_i,
  input  logic signed [dtas_pkg::FULL_W-1:0] full_i,
  input  logic [dtas_pkg::LVL_W-1:0]         level_i,
  input  logic                               bit_i,
  output dtas_pkg::div_cell_t                cell_o
);

  logic signed [dtas_pkg::FULL_W:0] raw_s;
  logic signed [dtas_pkg::FULL_W:0] rel_s;
  logic signed [dtas_pkg::FULL_W:0] full_s;
  logic [dtas_pkg::FULL_W-1:0]      span;
  logic [dtas_pkg::ADC_W-1:0]       diff;

  assign raw_s  = $signed({2'b00, raw_i});
  assign rel_s  = $signed({2'b00, release_i});
  assign full_s = $signed({full_i[dtas_pkg::FULL_W-1], full_i});
  assign span   = {1'b0, release_i} - $unsigned(full_i);
  assign diff   = release_i - raw_i;

  always_comb begin
    if (raw_i >= release_i) begin
      cell_o.mode = dtas_pkg::MODE_ZERO;
    end else if (raw_s <= full_s) begin
      cell_o.mode = dtas_pkg::MODE_FULL;
    end else if (rel_s <= full_s) begin
      cell_o.mode = dtas_pkg::MODE_ZERO;
    end else begin
      cell_o.mode = dtas_pkg::MODE_DIV;
    end
    cell_o.level_in = level_i;
    cell_o.bit_in   = bit_i;
    cell_o.rem      = {{(dtas_pkg::DIV_W-dtas_pkg::ADC_W){1'b0}}, diff}
                    * {{(dtas_pkg::DIV_W-dtas_pkg::LVL_W){1'b0}}, dtas_pkg::LEVEL_MAX};
    cell_o.dvs      = {span, {(dtas_pkg::QUO_W-1){1'b0}}};
    cell_o.quo      = '0;
  end

endmodule

@@ rtl/core/dtas_div_cell.sv @@
// ----------------------------------------------------------------------------
// Dual trigger ADC scaler division cell
// One registered restoring division step, producing one quotient bit.
// ----------------------------------------------------------------------------
module dtas_div_cell (
  input  logic                clk_i,
  input  dtas_pkg::div_cell_t cell_i,
  output dtas_pkg::div_cell_t cell_o
);

  dtas_pkg::div_cell_t cell_d;
  dtas_pkg::div_cell_t cell_q;
  logic                ge;

  assign ge = cell_i.rem >= cell_i.dvs;

  always_comb begin
    cell_d     = cell_i;
    cell_d.rem = ge ? (cell_i.rem - cell_i.dvs) : cell_i.rem;
    cell_d.dvs = cell_i.dvs >> 1;
    cell_d.quo = {cell_i.quo[dtas_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

@@ rtl/core/dtas_merge.sv @@
// ----------------------------------------------------------------------------
// Dual trigger ADC scaler channel merge
// Forms the hardware level and merges it with the incoming level and bit.
// ----------------------------------------------------------------------------
module dtas_merge (
  input  dtas_pkg::div_cell_t         cell_i,
  output logic [dtas_pkg::LVL_W-1:0]  level_o,
  output logic                        bit_o
);

  logic [dtas_pkg::LVL_W-1:0] hw;
  logic [dtas_pkg::LVL_W-1:0] level;
  logic                       trig;

  always_comb begin
    case (cell_i.mode)
      dtas_pkg::MODE_FULL: hw = dtas_pkg::LEVEL_MAX;
      dtas_pkg::MODE_DIV:  hw = cell_i.quo;
      default:             hw = '0;
    endcase

    if (cell_i.bit_in && (cell_i.level_in > hw)) begin
      level = cell_i.level_in;
    end else begin
      level = hw;
    end

    if (hw != '0) begin
      trig = 1'b1;
    end else if (level == '0) begin
      trig = 1'b0;
    end else begin
      trig = cell_i.bit_in;
    end

    level_o = (trig && (level == '0)) ? dtas_pkg::LEVEL_MAX : level;
    bit_o   = trig;
  end

endmodule

@@ rtl/core/dual_trigger_adc_scaler.sv @@
// ----------------------------------------------------------------------------
// Dual trigger ADC scaler
// Scales two raw trigger samples to 8-bit levels and merges them with levels
// and digital bits set elsewhere.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy. Each
// result appears with result_valid_o after its item has passed one input
// register, a chain of eight division cells that each produce one quotient
// bit, and one output register. Results are held for one cycle only, so the
// receiver must take every item as it is strobed.
// Thresholds should be written only while no item is in flight.
module dual_trigger_adc_scaler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  dtas_pkg::in_item_t              item_i,
  output logic                            result_valid_o,
  output dtas_pkg::out_item_t             result_o,
  input  logic                            cfg_we_i,
  input  logic [dtas_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [dtas_pkg::FULL_W-1:0]     cfg_data_i
);

  logic [dtas_pkg::ADC_W-1:0]  rel_l_q;
  logic [dtas_pkg::FULL_W-1:0] full_l_q;
  logic [dtas_pkg::ADC_W-1:0]  rel_r_q;
  logic [dtas_pkg::FULL_W-1:0] full_r_q;

  dtas_pkg::div_cell_t         prep_l;
  dtas_pkg::div_cell_t         prep_r;
  dtas_pkg::div_cell_t         head_l_q;
  dtas_pkg::div_cell_t         head_r_q;
  dtas_pkg::div_cell_t         chain_l [dtas_pkg::QUO_W+1];
  dtas_pkg::div_cell_t         chain_r [dtas_pkg::QUO_W+1];
  logic [dtas_pkg::QUO_W:0]    vld_q;

  dtas_pkg::out_item_t         out_d;
  dtas_pkg::out_item_t         out_q;
  logic                        out_vld_q;
  logic                        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_l_q  <= dtas_pkg::RELEASE_RST;
      full_l_q <= dtas_pkg::FULL_RST;
      rel_r_q  <= dtas_pkg::RELEASE_RST;
      full_r_q <= dtas_pkg::FULL_RST;
    end else if (cfg_we_i) begin
      case (dtas_pkg::cfg_idx_e'(cfg_idx_i))
        dtas_pkg::CFG_LEFT_RELEASE:  rel_l_q  <= cfg_data_i[dtas_pkg::ADC_W-1:0];
        dtas_pkg::CFG_LEFT_FULL:     full_l_q <= cfg_data_i;
        dtas_pkg::CFG_RIGHT_RELEASE: rel_r_q  <= cfg_data_i[dtas_pkg::ADC_W-1:0];
        dtas_pkg::CFG_RIGHT_FULL:    full_r_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dtas_prep u_prep_l (
    .raw_i     (item_i.raw_left),
    .release_i (rel_l_q),
    .full_i    ($signed(full_l_q)),
    .level_i   (item_i.left_level_in),
    .bit_i     (item_i.left_bit_in),
    .cell_o    (prep_l)
  );

  dtas_prep u_prep_r (
    .raw_i     (item_i.raw_right),
    .release_i (rel_r_q),
    .full_i    ($signed(full_r_q)),
    .level_i   (item_i.right_level_in),
    .bit_i     (item_i.right_bit_in),
    .cell_o    (prep_r)
  );

  always_ff @(posedge clk_i) begin
    head_l_q <= prep_l;
    head_r_q <= prep_r;
  end

  assign chain_l[0] = head_l_q;
  assign chain_r[0] = head_r_q;

  for (genvar i = 0; i < dtas_pkg::QUO_W; i++) begin : g_cell
    dtas_div_cell u_cell_l (
      .clk_i  (clk_i),
      .cell_i (chain_l[i]),
      .cell_o (chain_l[i+1])
    );
    dtas_div_cell u_cell_r (
      .clk_i  (clk_i),
      .cell_i (chain_r[i]),
      .cell_o (chain_r[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[dtas_pkg::QUO_W-1:0], accept};
    end
  end

  dtas_merge u_merge_l (
    .cell_i  (chain_l[dtas_pkg::QUO_W]),
    .level_o (out_d.left_level_out),
    .bit_o   (out_d.left_bit_out)
  );

  dtas_merge u_merge_r (
    .cell_i  (chain_r[dtas_pkg::QUO_W]),
    .level_o (out_d.right_level_out),
    .bit_o   (out_d.right_bit_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[dtas_pkg::QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

@@ rtl/core/dtas_checker.sv @@
// ----------------------------------------------------------------------------
// Dual trigger ADC scaler checker
// Port-level assertions on timing and result consistency of the scaler.
// ----------------------------------------------------------------------------
`include "dual_trigger_adc_scaler_defines.svh"

module dtas_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic                result_valid_o,
  input  dtas_pkg::out_item_t result_o
);

  localparam int unsigned LAT = dtas_pkg::LATENCY;

  `DTAS_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy, "busy raised")

  `DTAS_ASSERT_DLY(a_result_follows, clk_i, rst_ni, start && !busy, LAT, result_valid_o, "result missing after accepted item")

  `DTAS_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, result_valid_o, $past(start, LAT) && !$past(busy, LAT), "result without accepted item")

  `DTAS_ASSERT_IMP(a_bit_level, clk_i, rst_ni, result_valid_o, (!result_o.left_bit_out || (result_o.left_level_out != '0)) && (!result_o.right_bit_out || (result_o.right_level_out != '0)), "pressed bit with zero level")

endmodule

bind dual_trigger_adc_scaler dtas_checker u_dtas_checker (.*);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Dual trigger ADC scaler testbench
// Drives raw trigger samples with merged levels and bits through the scaler
// under a series of threshold settings. A scoreboard predicts every result
// and compares it field by field with what the block strobes out.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  dtas_pkg::in_item_t            item_i;
  logic                          result_valid_o;
  dtas_pkg::out_item_t           result_o;
  logic                          cfg_we_i;
  logic [dtas_pkg::IDX_W-1:0]    cfg_idx_i;
  logic [dtas_pkg::FULL_W-1:0]   cfg_data_i;

  dual_trigger_adc_scaler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  class trigger_level_scoreboard;
    logic [dtas_pkg::ADC_W-1:0]         left_release;
    logic signed [dtas_pkg::FULL_W-1:0] left_full;
    logic [dtas_pkg::ADC_W-1:0]         right_release;
    logic signed [dtas_pkg::FULL_W-1:0] right_full;
    dtas_pkg::out_item_t                level_q[$];
    int                                 errors;

    function new();
      left_release  = dtas_pkg::RELEASE_RST;
      left_full     = dtas_pkg::FULL_RST;
      right_release = dtas_pkg::RELEASE_RST;
      right_full    = dtas_pkg::FULL_RST;
      errors        = 0;
    endfunction

    function void load_threshold(dtas_pkg::cfg_idx_e idx,
                                 logic [dtas_pkg::FULL_W-1:0] value);
      case (idx)
        dtas_pkg::CFG_LEFT_RELEASE:  left_release  = value[dtas_pkg::ADC_W-1:0];
        dtas_pkg::CFG_LEFT_FULL:     left_full     = value;
        dtas_pkg::CFG_RIGHT_RELEASE: right_release = value[dtas_pkg::ADC_W-1:0];
        dtas_pkg::CFG_RIGHT_FULL:    right_full    = value;
        default: ;
      endcase
    endfunction

    function logic [dtas_pkg::LVL_W-1:0] sensor_level(
        logic [dtas_pkg::ADC_W-1:0] raw,
        logic [dtas_pkg::ADC_W-1:0] release_th,
        logic signed [dtas_pkg::FULL_W-1:0] full_th);
      int r;
      int rl;
      int f;
      r  = int'(raw);
      rl = int'(release_th);
      f  = int'(full_th);
      if (r >= rl) return '0;
      if (r <= f) return dtas_pkg::LEVEL_MAX;
      if (rl <= f) return '0;
      return dtas_pkg::LVL_W'(((rl - r) * int'(dtas_pkg::LEVEL_MAX)) / (rl - f));
    endfunction

    function void merge_level(logic [dtas_pkg::LVL_W-1:0] hw,
                              logic [dtas_pkg::LVL_W-1:0] level_in,
                              logic bit_in,
                              output logic [dtas_pkg::LVL_W-1:0] level_out,
                              output logic bit_out);
      logic [dtas_pkg::LVL_W-1:0] lvl;
      logic                       b;
      b = bit_in;
      if (bit_in) lvl = (hw > level_in) ? hw : level_in;
      else lvl = hw;
      if (hw != '0) b = 1'b1;
      else if (lvl == '0) b = 1'b0;
      if (b && lvl == '0) lvl = dtas_pkg::LEVEL_MAX;
      level_out = lvl;
      bit_out   = b;
    endfunction

    function void note_sample(dtas_pkg::in_item_t s);
      dtas_pkg::out_item_t o;
      merge_level(sensor_level(s.raw_left, left_release, left_full),
                  s.left_level_in, s.left_bit_in, o.left_level_out, o.left_bit_out);
      merge_level(sensor_level(s.raw_right, right_release, right_full),
                  s.right_level_in, s.right_bit_in, o.right_level_out, o.right_bit_out);
      level_q.push_back(o);
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(dtas_pkg::out_item_t got);
      dtas_pkg::out_item_t want;
      if (level_q.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = level_q.pop_front();
      if (got.left_level_out !== want.left_level_out)
        report($sformatf("left_level_out %0d, predicted %0d",
                         got.left_level_out, want.left_level_out));
      if (got.right_level_out !== want.right_level_out)
        report($sformatf("right_level_out %0d, predicted %0d",
                         got.right_level_out, want.right_level_out));
      if (got.left_bit_out !== want.left_bit_out)
        report($sformatf("left_bit_out %0b, predicted %0b",
                         got.left_bit_out, want.left_bit_out));
      if (got.right_bit_out !== want.right_bit_out)
        report($sformatf("right_bit_out %0b, predicted %0b",
                         got.right_bit_out, want.right_bit_out));
    endtask
  endclass

  trigger_level_scoreboard sb = new();
  int idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("testbench: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  task send_sample(dtas_pkg::in_item_t s);
    @(negedge clk_i);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= s;
    do begin
      @(posedge clk_i);
    end while (busy);
    sb.note_sample(s);
  endtask

  task drain;
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.level_q.size() != 0) @(posedge clk_i);
  endtask

  task write_threshold(dtas_pkg::cfg_idx_e idx, logic [dtas_pkg::FULL_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.load_threshold(idx, value);
  endtask

  task set_thresholds(int lrel, int lfull, int rrel, int rfull);
    drain();
    repeat (dtas_pkg::LATENCY + 2) @(posedge clk_i);
    write_threshold(dtas_pkg::CFG_LEFT_RELEASE, dtas_pkg::FULL_W'(lrel));
    write_threshold(dtas_pkg::CFG_LEFT_FULL, dtas_pkg::FULL_W'(lfull));
    write_threshold(dtas_pkg::CFG_RIGHT_RELEASE, dtas_pkg::FULL_W'(rrel));
    write_threshold(dtas_pkg::CFG_RIGHT_FULL, dtas_pkg::FULL_W'(rfull));
  endtask

  function automatic logic [dtas_pkg::ADC_W-1:0] pick_raw(int rel, int full);
    int v;
    case ($urandom_range(5))
      0: v = int'($urandom_range(4095));
      1: v = rel + int'($urandom_range(6)) - 3;
      2: v = full + int'($urandom_range(6)) - 3;
      3: v = (rel > full + 1) ? full + 1 + int'($urandom_range(rel - full - 2)) :
                                int'($urandom_range(4095));
      4: v = $urandom_range(1) ? 0 : 4095;
      default: v = int'($urandom_range(4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return dtas_pkg::ADC_W'(v);
  endfunction

  function automatic logic [dtas_pkg::LVL_W-1:0] pick_level();
    int p;
    p = int'($urandom_range(99));
    if (p < 25) return '0;
    if (p < 35) return dtas_pkg::LEVEL_MAX;
    return dtas_pkg::LVL_W'($urandom_range(255));
  endfunction

  function automatic dtas_pkg::in_item_t mk_sample(int rl, int rr, int ll, int lr,
                                                   bit bl, bit br);
    dtas_pkg::in_item_t s;
    s.raw_left       = dtas_pkg::ADC_W'(rl);
    s.raw_right      = dtas_pkg::ADC_W'(rr);
    s.left_level_in  = dtas_pkg::LVL_W'(ll);
    s.right_level_in = dtas_pkg::LVL_W'(lr);
    s.left_bit_in    = bl;
    s.right_bit_in   = br;
    return s;
  endfunction

  initial begin
    dtas_pkg::in_item_t s;
    int lr;
    int lf;
    int rr;
    int rf;
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    idle_pct   = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_sample(mk_sample(0, 4095, 0, 0, 0, 0));
    send_sample(mk_sample(4095, 0, 255, 255, 1, 1));
    send_sample(mk_sample(1, 4094, 0, 0, 1, 1));
    send_sample(mk_sample(4094, 1, 100, 200, 1, 0));
    send_sample(mk_sample(4095, 4095, 0, 0, 1, 0));
    send_sample(mk_sample(4095, 4095, 77, 200, 0, 1));
    send_sample(mk_sample(2048, 2047, 255, 0, 1, 1));
    send_sample(mk_sample(2048, 2047, 255, 0, 0, 0));
    send_sample(mk_sample(4000, 3000, 10, 250, 1, 1));
    send_sample(mk_sample(2730, 1365, 170, 85, 1, 1));
    send_sample(mk_sample(1365, 2730, 170, 85, 0, 1));

    set_thresholds(4095, -1, 0, 4095);
    send_sample(mk_sample(0, 0, 0, 0, 0, 0));
    send_sample(mk_sample(1, 4095, 0, 0, 1, 1));
    send_sample(mk_sample(4095, 2000, 128, 128, 1, 0));
    set_thresholds(100, 3000, 1500, 1500);
    send_sample(mk_sample(50, 1500, 0, 0, 0, 0));
    send_sample(mk_sample(2000, 1499, 0, 0, 0, 1));
    send_sample(mk_sample(3500, 1501, 5, 0, 1, 1));
    send_sample(mk_sample(3000, 1000, 255, 255, 0, 0));

    for (int phase = 0; phase < 9; phase++) begin
      case (phase / 3)
        0: idle_pct = 29;
        1: idle_pct = 84;
        default: idle_pct = 0;
      endcase
      case (phase)
        0: set_thresholds(4095, -1, 0, 4095);
        1: set_thresholds(0, -4096, 4095, 4095);
        2: set_thresholds(2000, 1000, 1500, 1500);
        3: set_thresholds(100, 3000, 3000, -1);
        default: begin
          lr = int'($urandom_range(4095));
          rr = int'($urandom_range(4095));
          lf = $urandom_range(9) == 0 ? -int'($urandom_range(1, 4096)) :
                                        int'($urandom_range(4096)) - 1;
          rf = $urandom_range(9) == 0 ? -int'($urandom_range(1, 4096)) :
                                        int'($urandom_range(4096)) - 1;
          if ($urandom_range(1)) begin
            lf = int'($urandom_range(lr)) - 1;
            rf = int'($urandom_range(rr)) - 1;
          end
          set_thresholds(lr, lf, rr, rf);
        end
      endcase
      for (int n = 0; n < 110; n++) begin
        if (n == 55) drain();
        s.raw_left       = pick_raw(int'(sb.left_release), int'(sb.left_full));
        s.raw_right      = pick_raw(int'(sb.right_release), int'(sb.right_full));
        s.left_level_in  = pick_level();
        s.right_level_in = pick_level();
        s.left_bit_in    = 1'($urandom_range(1));
        s.right_bit_in   = 1'($urandom_range(1));
        send_sample(s);
      end
    end

    drain();
    repeat (dtas_pkg::LATENCY + 4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ dual_trigger_adc_scaler.f @@
+incdir+rtl/core
rtl/core/dtas_pkg.sv
rtl/core/dtas_prep.sv
rtl/core/dtas_div_cell.sv
rtl/core/dtas_merge.sv
rtl/core/dual_trigger_adc_scaler.sv
rtl/core/dtas_checker.sv
bench/testbench.sv
